// ----- design/csv_column_splitter_core_defines.svh -----
// Assertion macros used by the checker file of the CSV column splitter.
// Depends on nothing; include by bare file name.
`ifndef CSV_COLUMN_SPLITTER_CORE_DEFINES_SVH
`define CSV_COLUMN_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CSVS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csvs check failed");

// Next-cycle implication, disabled during reset
`define CSVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csvs check failed");

// Condition that must hold in the cycle after reset is applied
`define CSVS_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("csvs check failed after reset");

`endif

// ----- design/csvs_pkg.sv -----
// Types and constants of the CSV column splitter.
// Used by every module of the block but csvs_fifo; depends on nothing.
`timescale 1ns / 1ps

package csvs_pkg;

   // Input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  content_byte;
      logic [6:0]  column_index;
      logic [15:0] column_length;
      logic [1:0]  status;
   } rsp_type;

   // Classified byte handed from the front end to the parse engine
   typedef struct packed {
      logic [7:0] data_byte;
      logic       eos;
      logic       is_nul;
      logic       is_eol;
      logic       is_delim;
      logic       is_quote;
      logic       is_bs;
      logic       is_blank;
   } cls_type;

   // Result kinds
   localparam logic [1:0] KIND_CONTENT = 2'd0;
   localparam logic [1:0] KIND_COLUMN  = 2'd1;
   localparam logic [1:0] KIND_RECORD  = 2'd2;
   localparam logic [1:0] KIND_STREAM  = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_MIDREC   = 2'd2;

   // Register indexes
   localparam logic CSR_DELIMITER = 1'b0;
   localparam logic CSR_EXPECTED  = 1'b1;

   // Register reset values
   localparam logic [7:0] DELIMITER_RESET = 8'h2C;
   localparam logic [6:0] EXPECTED_RESET  = 7'd1;

   // Special bytes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BS    = 8'h5C;

   // Queue depths
   localparam int REQ_FIFO_DEPTH = 4;
   localparam int RSP_FIFO_DEPTH = 2;

   localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

endpackage

// ----- design/csv_column_splitter_core.sv -----
// CSV column splitter: one raw byte or end-of-stream mark per transaction.
// A byte's result reaches the result ports through the front queue and then the result queue.
// Throughput: one byte per cycle while the result queue has room; the parse engine is combinational.
// Reset (synchronous, active high): queues empty, parser at record start,
// delimiter ',' and expected columns 1; no clearing pass.
`timescale 1ns / 1ps

module csv_column_splitter_core import csvs_pkg::*; #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  req_type    req_data,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_wen,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic [7:0] delimiter_ff;
   logic [6:0] expected_ff;
   cls_type    item;
   logic       item_valid;
   logic       item_pop;
   logic       out_full;
   logic       out_push;
   rsp_type    out_data;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DELIMITER_RESET;
         expected_ff  <= EXPECTED_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_DELIMITER: delimiter_ff <= csr_wdata;
            CSR_EXPECTED:  expected_ff  <= csr_wdata[6:0];
            default:       delimiter_ff <= delimiter_ff;
         endcase
      end
   end

   csvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .delimiter  (delimiter_ff),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   csvs_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .item_valid       (item_valid),
      .item_pop         (item_pop),
      .expected_columns (expected_ff),
      .out_full         (out_full),
      .rsp_push         (out_push),
      .rsp_data         (out_data)
   );

   csvs_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

// ----- design/csvs_fifo.sv -----
// Small synchronous FIFO in flip-flops, first-word fall-through.
// Generic; depends on nothing.
`timescale 1ns / 1ps

module csvs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- design/csvs_front.sv -----
// Front end: accepts input transactions, classifies each byte, and queues it.
// Depends on csvs_pkg and csvs_fifo.
`timescale 1ns / 1ps

module csvs_front import csvs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  req_type    req_data,
   output logic       req_full,
   input  logic [7:0] delimiter,
   output cls_type    item,
   output logic       item_valid,
   input  logic       item_pop
);

   cls_type cls;
   logic    q_empty;

   // Classify the incoming byte
   always_comb begin
      cls.data_byte = req_data.data_byte;
      cls.eos       = req_data.end_of_stream;
      cls.is_nul    = (req_data.data_byte == CHAR_NUL);
      cls.is_eol    = (req_data.data_byte == CHAR_CR) || (req_data.data_byte == CHAR_LF);
      cls.is_delim  = (req_data.data_byte == delimiter);
      cls.is_quote  = (req_data.data_byte == CHAR_QUOTE);
      cls.is_bs     = (req_data.data_byte == CHAR_BS);
      cls.is_blank  = (req_data.data_byte == CHAR_SPACE) || (req_data.data_byte == CHAR_TAB);
   end

   csvs_fifo #(
      .WIDTH ($bits(cls_type)),
      .DEPTH (REQ_FIFO_DEPTH)
   ) u_cls_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls),
      .full  (req_full),
      .pop   (item_pop),
      .rdata (item),
      .empty (q_empty)
   );

   assign item_valid = !q_empty;

endmodule

// ----- design/csvs_back.sv -----
// Parse engine: applies quote, escape and record rules to each classified byte.
// Depends on csvs_pkg.
`timescale 1ns / 1ps

module csvs_back import csvs_pkg::*; #(
   parameter int MAX_COLUMNS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cls_type    item,
   input  logic       item_valid,
   output logic       item_pop,
   input  logic [6:0] expected_columns,
   input  logic       out_full,
   output logic       rsp_push,
   output rsp_type    rsp_data
);

   localparam logic [6:0] COL_CAP = 7'((MAX_COLUMNS > 127) ? 127 : MAX_COLUMNS);

   logic        in_quotes_ff, in_quotes_in;
   logic        opened_quote_ff, opened_quote_in;
   logic        any_quote_ff, any_quote_in;
   logic        prev_quote_ff, prev_quote_in;
   logic        escape_ff, escape_in;
   logic        only_spaces_ff, only_spaces_in;
   logic        record_start_ff, record_start_in;
   logic [6:0]  columns_ff, columns_in;
   logic [15:0] length_ff, length_in;

   logic        fire;
   logic        produce;
   logic        plain;
   logic        emit_content;
   logic [7:0]  content_val;
   logic [7:0]  total;
   logic        count_ok;
   logic [15:0] length_inc;

   assign fire       = item_valid && !out_full;
   assign item_pop   = fire;
   assign rsp_push   = fire && produce;
   assign plain      = !(item.is_nul || item.is_eol || item.is_delim || item.is_quote
                         || item.is_bs);
   assign total      = {1'b0, columns_ff} + 8'd1;
   assign count_ok   = (total == {1'b0, expected_columns}) && (expected_columns <= COL_CAP);
   assign length_inc = (length_ff < LENGTH_MAX) ? length_ff + 16'd1 : length_ff;

   // Decide next parser state and the result for the head byte
   always_comb begin
      in_quotes_in    = in_quotes_ff;
      opened_quote_in = opened_quote_ff;
      any_quote_in    = any_quote_ff;
      prev_quote_in   = prev_quote_ff;
      escape_in       = escape_ff;
      only_spaces_in  = only_spaces_ff;
      record_start_in = record_start_ff;
      columns_in      = columns_ff;
      length_in       = length_ff;
      produce         = 1'b0;
      emit_content    = 1'b0;
      content_val     = item.data_byte;
      rsp_data        = '0;

      if (item.eos) begin
         // Report stream end, return to reset state
         produce              = 1'b1;
         rsp_data.kind        = KIND_STREAM;
         rsp_data.status      = record_start_ff ? STATUS_OK : STATUS_MIDREC;
         in_quotes_in         = 1'b0;
         opened_quote_in      = 1'b0;
         any_quote_in         = 1'b0;
         prev_quote_in        = 1'b0;
         escape_in            = 1'b0;
         only_spaces_in       = 1'b1;
         length_in            = '0;
         record_start_in      = 1'b1;
         columns_in           = '0;
      end else if (record_start_ff && item.is_eol) begin
         // Drop line breaks at record start
         produce = 1'b0;
      end else begin
         record_start_in = 1'b0;
         escape_in       = 1'b0;
         prev_quote_in   = 1'b0;
         if (plain) begin
            only_spaces_in = only_spaces_ff && item.is_blank;
            emit_content   = 1'b1;
         end else if (!in_quotes_ff && !item.is_delim && (item.is_bs || escape_ff)) begin
            if (escape_ff) begin
               emit_content = 1'b1;
            end else begin
               escape_in = 1'b1;
            end
         end else if (item.is_quote) begin
            if (only_spaces_ff && !any_quote_ff) begin
               in_quotes_in    = 1'b1;
               opened_quote_in = 1'b1;
            end else if (in_quotes_ff) begin
               in_quotes_in = 1'b0;
            end else if (opened_quote_ff && any_quote_ff && prev_quote_ff) begin
               in_quotes_in = 1'b1;
               emit_content = 1'b1;
               content_val  = CHAR_QUOTE;
            end else begin
               emit_content = 1'b1;
               content_val  = CHAR_QUOTE;
            end
            any_quote_in  = 1'b1;
            prev_quote_in = 1'b1;
         end else if (in_quotes_ff) begin
            emit_content = 1'b1;
         end else if (item.is_nul || item.is_eol) begin
            // Close last column and the record
            produce                = 1'b1;
            rsp_data.kind          = KIND_RECORD;
            rsp_data.column_index  = columns_ff;
            rsp_data.column_length = length_ff;
            rsp_data.status        = count_ok ? STATUS_OK : STATUS_MISMATCH;
            in_quotes_in           = 1'b0;
            opened_quote_in        = 1'b0;
            any_quote_in           = 1'b0;
            only_spaces_in         = 1'b1;
            length_in              = '0;
            record_start_in        = 1'b1;
            columns_in             = '0;
         end else begin
            // Close column on delimiter
            produce                = 1'b1;
            rsp_data.kind          = KIND_COLUMN;
            rsp_data.column_index  = columns_ff;
            rsp_data.column_length = length_ff;
            rsp_data.status        = STATUS_OK;
            if (columns_ff < COL_CAP) begin
               columns_in = columns_ff + 7'd1;
            end
            in_quotes_in    = 1'b0;
            opened_quote_in = 1'b0;
            any_quote_in    = 1'b0;
            only_spaces_in  = 1'b1;
            length_in       = '0;
         end

         if (emit_content) begin
            produce               = 1'b1;
            length_in             = length_inc;
            rsp_data.kind         = KIND_CONTENT;
            rsp_data.content_byte = content_val;
            rsp_data.column_index = columns_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff    <= 1'b0;
         opened_quote_ff <= 1'b0;
         any_quote_ff    <= 1'b0;
         prev_quote_ff   <= 1'b0;
         escape_ff       <= 1'b0;
         only_spaces_ff  <= 1'b1;
         record_start_ff <= 1'b1;
         columns_ff      <= '0;
         length_ff       <= '0;
      end else if (fire) begin
         in_quotes_ff    <= in_quotes_in;
         opened_quote_ff <= opened_quote_in;
         any_quote_ff    <= any_quote_in;
         prev_quote_ff   <= prev_quote_in;
         escape_ff       <= escape_in;
         only_spaces_ff  <= only_spaces_in;
         record_start_ff <= record_start_in;
         columns_ff      <= columns_in;
         length_ff       <= length_in;
      end
   end

endmodule

// ----- design/csvs_checker.sv -----
// Port-level checks for csv_column_splitter_core, attached by bind.
// Depends on csvs_pkg and csv_column_splitter_core_defines.svh.
`timescale 1ns / 1ps
`include "csv_column_splitter_core_defines.svh"

module csvs_checker import csvs_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input rsp_type    rsp_data
);

   // After reset the result queue is empty and the front queue is not full
   `CSVS_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, rsp_empty && !req_full)

   // A waiting result holds until popped
   `CSVS_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

   // Content transactions carry no length and no status
   `CSVS_ASSERT_IMPL(a_content_clean, clock, reset, !rsp_empty && rsp_data.kind == KIND_CONTENT, rsp_data.column_length == 16'd0 && rsp_data.status == STATUS_OK)

   // Column ends and stream ends use only their own status codes
   `CSVS_ASSERT_IMPL(a_status_kind, clock, reset, !rsp_empty && rsp_data.kind != KIND_RECORD, rsp_data.status != STATUS_MISMATCH)

endmodule

bind csv_column_splitter_core csvs_checker u_csvs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// ----- tb/sv/csv_column_splitter_core_tb.sv -----
// Self-checking testbench of the CSV column splitter core.
// Predicts every result transaction from the raw byte stream and checks it in order.
// Depends on csvs_pkg and csv_column_splitter_core.
`timescale 1ns / 1ps

module csv_column_splitter_core_tb;
   import csvs_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 125;
   localparam int SETTLE_TICKS = 8;

   // Parser state tracker: turns accepted bytes into the expected token stream
   class csv_token_tracker;
      localparam int COL_CAP = 64;

      logic [7:0]  delim;
      logic [6:0]  want_cols;
      bit          in_quotes;
      bit          opened_quote;
      bit          quote_seen;
      bit          last_was_quote;
      bit          escape_open;
      bit          blanks_only;
      bit          record_start;
      logic [6:0]  cols_done;
      logic [15:0] col_len;
      rsp_type     pending_tokens[$];
      int          errors;

      function new();
         delim = DELIMITER_RESET;
         want_cols = EXPECTED_RESET;
         errors = 0;
         clear_record();
      endfunction

      function void clear_column();
         in_quotes = 1'b0;
         opened_quote = 1'b0;
         quote_seen = 1'b0;
         last_was_quote = 1'b0;
         escape_open = 1'b0;
         blanks_only = 1'b1;
         col_len = '0;
      endfunction

      function void clear_record();
         clear_column();
         record_start = 1'b1;
         cols_done = '0;
      endfunction

      function void set_reg(logic idx, logic [7:0] value);
         if (idx == CSR_DELIMITER) begin
            delim = value;
         end else begin
            want_cols = value[6:0];
         end
      endfunction

      function int pending();
         return pending_tokens.size();
      endfunction

      // Count one content byte of the open column, saturating
      function rsp_type content_token(logic [7:0] b);
         rsp_type t;
         t = '0;
         if (col_len != LENGTH_MAX) col_len++;
         t.kind = KIND_CONTENT;
         t.content_byte = b;
         t.column_index = cols_done;
         return t;
      endfunction

      // Advance the parser by one accepted transaction
      function void note_byte(req_type item);
         rsp_type    tok;
         bit         emit;
         logic [7:0] b;
         bit         is_nul, is_eol, is_delim, is_quote, is_bs, was_esc, was_quote;
         tok = '0;
         emit = 1'b0;
         b = item.data_byte;
         if (item.end_of_stream) begin
            tok.kind = KIND_STREAM;
            tok.status = record_start ? STATUS_OK : STATUS_MIDREC;
            clear_record();
            emit = 1'b1;
         end else if (!(record_start && (b == CHAR_CR || b == CHAR_LF))) begin
            record_start = 1'b0;
            is_nul = (b == CHAR_NUL);
            is_eol = (b == CHAR_CR || b == CHAR_LF);
            is_delim = (b == delim);
            is_quote = (b == CHAR_QUOTE);
            is_bs = (b == CHAR_BS);
            was_esc = escape_open;
            was_quote = last_was_quote;
            escape_open = 1'b0;
            last_was_quote = 1'b0;
            if (!(is_nul || is_eol || is_delim || is_quote || is_bs)) begin
               blanks_only = blanks_only && (b == CHAR_SPACE || b == CHAR_TAB);
               tok = content_token(b);
               emit = 1'b1;
            end else if (!in_quotes && !is_delim && (is_bs || was_esc)) begin
               if (was_esc) begin
                  tok = content_token(b);
                  emit = 1'b1;
               end else begin
                  escape_open = 1'b1;
               end
            end else if (is_quote) begin
               if (blanks_only && !quote_seen) begin
                  in_quotes = 1'b1;
                  opened_quote = 1'b1;
               end else if (in_quotes) begin
                  in_quotes = 1'b0;
               end else if (opened_quote && quote_seen && was_quote) begin
                  // doubled quote: literal quote, stay quoted
                  in_quotes = 1'b1;
                  tok = content_token(CHAR_QUOTE);
                  emit = 1'b1;
               end else begin
                  tok = content_token(CHAR_QUOTE);
                  emit = 1'b1;
               end
               quote_seen = 1'b1;
               last_was_quote = 1'b1;
            end else if (in_quotes) begin
               tok = content_token(b);
               emit = 1'b1;
            end else if (is_nul || is_eol) begin
               // record end closes the last column too
               tok.kind = KIND_RECORD;
               tok.column_index = cols_done;
               tok.column_length = col_len;
               tok.status = (int'(cols_done) + 1 == int'(want_cols) &&
                             int'(want_cols) <= COL_CAP) ? STATUS_OK : STATUS_MISMATCH;
               clear_record();
               emit = 1'b1;
            end else begin
               tok.kind = KIND_COLUMN;
               tok.column_index = cols_done;
               tok.column_length = col_len;
               if (int'(cols_done) < COL_CAP) cols_done++;
               clear_column();
               emit = 1'b1;
            end
         end
         if (emit) pending_tokens.push_back(tok);
      endfunction

      task report_mismatch(string what, logic [15:0] got_v, logic [15:0] exp_v);
         if (errors < 40) $display("mismatch on %s: got %0h, expected %0h", what, got_v, exp_v);
         errors++;
      endtask

      // Compare one popped result with the oldest expected token
      task check_token(rsp_type got);
         rsp_type want;
         if (pending_tokens.size() == 0) begin
            report_mismatch("unexpected result kind", 16'(got.kind), '0);
         end else begin
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind)
               report_mismatch("kind", 16'(got.kind), 16'(want.kind));
            if (got.content_byte !== want.content_byte)
               report_mismatch("content_byte", 16'(got.content_byte), 16'(want.content_byte));
            if (got.column_index !== want.column_index)
               report_mismatch("column_index", 16'(got.column_index), 16'(want.column_index));
            if (got.column_length !== want.column_length)
               report_mismatch("column_length", got.column_length, want.column_length);
            if (got.status !== want.status)
               report_mismatch("status", 16'(got.status), 16'(want.status));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   req_type    req_data = '0;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wen = 1'b0;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   csv_token_tracker tracker = new();
   req_type          byte_stream[$];
   bit               quiet = 1'b0;
   int               cycles = 0;

   csv_column_splitter_core dut (
      .clock, .reset, .req_push, .req_data, .req_full, .rsp_empty, .rsp_pop, .rsp_data,
      .csr_wen, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic bit take_break();
      return !quiet && ($urandom_range(0, 99) < 14);
   endfunction

   // Result side: check each popped transaction, stall at random
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) tracker.check_token(rsp_data);
         rsp_pop <= !take_break();
      end
   end

   // Random byte that is content everywhere under delimiter d
   function automatic logic [7:0] plain_byte(logic [7:0] d);
      logic [7:0] b;
      do begin
         b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(32, 126));
      end while (b == d || b == CHAR_QUOTE || b == CHAR_BS || b == CHAR_CR ||
                 b == CHAR_LF || b == CHAR_NUL);
      return b;
   endfunction

   function automatic logic [7:0] special_byte(logic [7:0] d);
      case ($urandom_range(0, 6))
         0: return d;
         1: return CHAR_QUOTE;
         2: return CHAR_BS;
         3: return CHAR_CR;
         4: return CHAR_LF;
         5: return CHAR_NUL;
         default: return plain_byte(d);
      endcase
   endfunction

   task automatic queue_byte(logic [7:0] b);
      req_type t;
      t.data_byte = b;
      t.end_of_stream = 1'b0;
      byte_stream.push_back(t);
   endtask

   task automatic queue_eos();
      req_type t;
      t.data_byte = 8'($urandom_range(0, 255));
      t.end_of_stream = 1'b1;
      byte_stream.push_back(t);
   endtask

   // One column body in one of several shapes
   task automatic queue_field(logic [7:0] d);
      case ($urandom_range(0, 5))
         0: ;
         1: repeat ($urandom_range(1, 6)) queue_byte(plain_byte(d));
         2: begin
            repeat ($urandom_range(0, 2)) queue_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
            queue_byte(CHAR_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 5))
                  0: begin
                     queue_byte(CHAR_QUOTE);
                     queue_byte(CHAR_QUOTE);
                  end
                  1: queue_byte(d);
                  2: queue_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                  3: queue_byte(CHAR_BS);
                  default: queue_byte(plain_byte(d));
               endcase
            end
            queue_byte(CHAR_QUOTE);
            if ($urandom_range(0, 3) == 0) queue_byte(plain_byte(d));
         end
         3: begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1)) begin
                  queue_byte(CHAR_BS);
                  queue_byte(special_byte(d));
               end else begin
                  queue_byte(plain_byte(d));
               end
            end
            if ($urandom_range(0, 5) == 0) queue_byte(CHAR_BS);
         end
         4: begin
            queue_byte(plain_byte(d));
            queue_byte(CHAR_QUOTE);
            queue_byte(plain_byte(d));
         end
         default: repeat ($urandom_range(1, 3)) queue_byte(CHAR_SPACE);
      endcase
   endtask

   task automatic queue_record(logic [7:0] d, int ncols);
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) queue_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      for (int i = 0; i < ncols; i++) begin
         if (i > 0) queue_byte(d);
         queue_field(d);
      end
      case ($urandom_range(0, 4))
         1: begin
            queue_byte(CHAR_CR);
            queue_byte(CHAR_LF);
         end
         2: queue_byte(CHAR_CR);
         3: queue_byte(CHAR_NUL);
         default: queue_byte(CHAR_LF);
      endcase
   endtask

   // Mostly well-formed records, some off by one column, some noise and stream ends
   task automatic queue_random(logic [7:0] d, int cols, int budget);
      int r;
      int n;
      while (byte_stream.size() < budget) begin
         r = $urandom_range(0, 19);
         n = (cols < 1) ? 1 : (cols > 70 ? 70 : cols);
         if (r == 0) n = n + 1;
         else if (r == 1 && n > 1) n = n - 1;
         if (r < 15) begin
            queue_record(d, n);
         end else if (r < 18) begin
            repeat ($urandom_range(1, 8))
               queue_byte($urandom_range(0, 2) == 0 ? special_byte(d) : 8'($urandom_range(0, 255)));
         end else begin
            queue_eos();
         end
      end
   endtask

   // Offer one transaction and hold it until accepted
   task automatic send_item(req_type t);
      while (take_break()) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_full);
      tracker.note_byte(t);
   endtask

   task automatic send_stream();
      foreach (byte_stream[i]) send_item(byte_stream[i]);
      req_push <= 1'b0;
      byte_stream.delete();
   endtask

   // Drain every expected result, then let bytes without results flush
   task automatic wait_idle();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_reg(idx, value);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [7:0] d, logic [6:0] cols, bit calm);
      wait_idle();
      write_reg(CSR_DELIMITER, d);
      write_reg(CSR_EXPECTED, 8'(cols));
      quiet = calm;
      queue_random(d, int'(cols), PHASE_ITEMS);
      send_stream();
      quiet = 1'b0;
   endtask

   logic [7:0] phase_delims[9] = '{8'h2C, CHAR_TAB, 8'hFF, 8'h01, CHAR_QUOTE, CHAR_BS,
                                   CHAR_LF, 8'h00, 8'h3B};
   logic [6:0] phase_cols[9] = '{7'd3, 7'd4, 7'd64, 7'd2, 7'd2, 7'd3, 7'd2, 7'd0, 7'd127};

   // Directed opening under the reset settings: skipped line breaks, NUL record,
   // extreme bytes, backslash before the delimiter, escaped quote, quoted column after blanks with
   // doubled quote and literal backslash, stream end with and without a record open
   logic [7:0] opening[21] = '{CHAR_LF, CHAR_CR, CHAR_NUL, 8'h61, 8'hFF, 8'h2C,
                              CHAR_BS, 8'h2C, CHAR_BS, CHAR_QUOTE, 8'h2C,
                              CHAR_SPACE, CHAR_QUOTE, 8'h78, CHAR_QUOTE, CHAR_QUOTE,
                              CHAR_BS, 8'h2C, CHAR_QUOTE, 8'h79, CHAR_LF};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) queue_byte(opening[i]);
      queue_eos();
      queue_byte(8'h7A);
      queue_eos();
      send_stream();

      // Random traffic under the reset settings
      queue_random(DELIMITER_RESET, int'(EXPECTED_RESET), PHASE_ITEMS);
      send_stream();

      // Random traffic under each other setting; the first runs without idling
      for (int i = 0; i < 9; i++) begin
         run_phase(phase_delims[i], phase_cols[i], i == 0);
         if (phase_delims[i] == 8'hFF) begin
            // drive the column count past its ceiling
            queue_record(8'hFF, 66);
            send_stream();
         end
      end

      wait_idle();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/csvs_pkg.sv
design/csvs_fifo.sv
design/csvs_front.sv
design/csvs_back.sv
design/csv_column_splitter_core.sv
design/csvs_checker.sv
tb/sv/csv_column_splitter_core_tb.sv
